/* rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, widths and constants of the pure pursuit target selector.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned MaxWaypoints = 1024;
  localparam int unsigned IdxW         = $clog2(MaxWaypoints);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned PosW         = 24;
  localparam int unsigned SpdW         = 16;
  localparam int unsigned HdgW         = 16;
  localparam int unsigned TrigW        = 19;
  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned DivW         = 60;

  localparam logic signed [HdgW:0] HalfPiQ13 = 17'sd12868;
  localparam logic signed [HdgW:0] PiQ13     = 17'sd25736;
  localparam logic signed [26:0]   CordicK   = 27'sd10188014;

  // Configuration register indexes.
  localparam logic [2:0] CfgLookAhead = 3'd0;
  localparam logic [2:0] CfgSteerGain = 3'd1;
  localparam logic [2:0] CfgSpdScale  = 3'd2;
  localparam logic [2:0] CfgDriveEn   = 3'd3;
  localparam logic [2:0] CfgWpCount   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [TrigW-1:0] cos_v;
    logic signed [TrigW-1:0] sin_v;
  } sincos_t;

  function automatic logic [19:0] atan_q16(input logic [3:0] step);
    logic [19:0] r;
    case (step)
      4'd0:    r = 20'd51472;
      4'd1:    r = 20'd30386;
      4'd2:    r = 20'd16055;
      4'd3:    r = 20'd8150;
      4'd4:    r = 20'd4091;
      4'd5:    r = 20'd2047;
      4'd6:    r = 20'd1024;
      4'd7:    r = 20'd512;
      4'd8:    r = 20'd256;
      4'd9:    r = 20'd128;
      4'd10:   r = 20'd64;
      4'd11:   r = 20'd32;
      4'd12:   r = 20'd16;
      4'd13:   r = 20'd8;
      4'd14:   r = 20'd4;
      4'd15:   r = 20'd2;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/pps_cordic.sv */
// ----------------------------------------------------------------------------
// pps_cordic
// Sine and cosine of the heading, one CORDIC rotation step per cycle.
// ----------------------------------------------------------------------------
module pps_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [pps_pkg::HdgW-1:0] heading_i,
  output logic                          done_o,
  output pps_pkg::sincos_t              trig_o
);

  logic signed [26:0] x_q, x_d, y_q, y_d;
  logic signed [19:0] z_q, z_d;
  logic [3:0]         step_q, step_d;
  logic               busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic signed [pps_pkg::HdgW:0] h_ext, h_fold;
  logic signed [26:0] x_sh, y_sh, x_rnd, y_rnd;
  logic signed [pps_pkg::TrigW-1:0] c_v, s_v;

  always_comb begin
    h_ext  = {heading_i[pps_pkg::HdgW-1], heading_i};
    h_fold = h_ext;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    x_sh   = x_q >>> step_q;
    y_sh   = y_q >>> step_q;
    if (start_i) begin
      neg_d = 1'b0;
      if (h_ext > pps_pkg::HalfPiQ13) begin
        h_fold = h_ext - pps_pkg::PiQ13;
        neg_d  = 1'b1;
      end else if (h_ext < -pps_pkg::HalfPiQ13) begin
        h_fold = h_ext + pps_pkg::PiQ13;
        neg_d  = 1'b1;
      end
      x_d    = pps_pkg::CordicK;
      y_d    = '0;
      z_d    = {h_fold[pps_pkg::HdgW], h_fold[pps_pkg::HdgW-1:0], 3'b000};
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[19]) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - $signed(pps_pkg::atan_q16(step_q));
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + $signed(pps_pkg::atan_q16(step_q));
      end
      step_d = step_q + 4'd1;
      if (step_q == 4'(pps_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
  end

  // Round from 24 to 16 fraction bits, then undo the half-turn fold.
  always_comb begin
    x_rnd = (x_q + 27'sd128) >>> 8;
    y_rnd = (y_q + 27'sd128) >>> 8;
    c_v   = neg_q ? -x_rnd[pps_pkg::TrigW-1:0] : x_rnd[pps_pkg::TrigW-1:0];
    s_v   = neg_q ? -y_rnd[pps_pkg::TrigW-1:0] : y_rnd[pps_pkg::TrigW-1:0];
  end

  assign done_o       = done_q;
  assign trig_o.cos_v = c_v;
  assign trig_o.sin_v = s_v;

endmodule

/* rtl/pps_divider.sv */
// ----------------------------------------------------------------------------
// pps_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pps_pkg::DivW-1:0]   dividend_i,
  input  logic [pps_pkg::DivW-2:0]   divisor_i,
  output logic                       done_o,
  output logic [pps_pkg::DivW-1:0]   quotient_o
);

  localparam int unsigned CW = $clog2(pps_pkg::DivW);

  logic [pps_pkg::DivW-1:0] num_q, num_d, rem_q, rem_d, rem_sh;
  logic [pps_pkg::DivW-2:0] den_q;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[pps_pkg::DivW-2:0], num_q[pps_pkg::DivW-1]};
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        num_d = {num_q[pps_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        num_d = {num_q[pps_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(pps_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

/* rtl/pure_pursuit_target_select_unit.sv */
// ----------------------------------------------------------------------------
// pure_pursuit_target_select_unit
// Waypoint table with a nearest forward target search and steering output.
// ----------------------------------------------------------------------------
//   Channel    Ports                         Carries
//   input      s_axis_* (tuser = req_type)   waypoint write or pose query
//   output     m_axis_* (tuser = found)      steering, speed, target index
//   config     cfg_we_i, cfg_idx_i, cfg_data_i   register writes
//
// A waypoint write is done in idle and does not leave it. A query runs through
// the CORDIC, a sweep of the n searched entries through the five-stage rotate
// and compare pipeline, the products, the bit-serial division, the load of the
// output register and the return to idle. Without a target the division is
// skipped. The table is not cleared by reset. A new item is taken while the
// previous result waits in the output register; a finished query holds the
// unit until that register is free.
// ----------------------------------------------------------------------------
module pure_pursuit_target_select_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // wp_index, wp_x, wp_y, wp_speed, pos_x, pos_y, heading
  input  logic [143:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // steering, speed_cmd, target_index
  output logic [47:0]  m_axis_tdata,
  // target_found
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [17:0]  cfg_data_i
);

  localparam int unsigned IW = pps_pkg::IdxW;
  localparam int unsigned NW = pps_pkg::CntW;

  // Configuration.
  logic [17:0] look_q;
  logic [15:0] gain_q, scale_q;
  logic        drive_q;
  logic [10:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q  <= 18'd7373;
      gain_q  <= 16'd3072;
      scale_q <= 16'd12616;
      drive_q <= 1'b1;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pps_pkg::CfgLookAhead: look_q  <= cfg_data_i;
        pps_pkg::CfgSteerGain: gain_q  <= cfg_data_i[15:0];
        pps_pkg::CfgSpdScale:  scale_q <= cfg_data_i[15:0];
        pps_pkg::CfgDriveEn:   drive_q <= cfg_data_i[0];
        pps_pkg::CfgWpCount:   count_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [IW-1:0]      in_idx;
  logic [63:0]        in_entry;
  logic signed [23:0] in_px, in_py;
  logic signed [15:0] in_hdg;
  assign in_idx   = s_axis_tdata[9:0];
  assign in_entry = s_axis_tdata[73:10];
  assign in_px    = s_axis_tdata[97:74];
  assign in_py    = s_axis_tdata[121:98];
  assign in_hdg   = s_axis_tdata[137:122];

  pps_pkg::state_e state_q, state_d;
  logic in_acc, is_query, is_write;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_query = in_acc && s_axis_tuser;
  assign is_write = in_acc && !s_axis_tuser;

  // Waypoint memory: {speed, y, x}.
  logic [63:0]   wp_mem [pps_pkg::MaxWaypoints];
  logic [63:0]   rd_data_q;
  logic [NW-1:0] rd_cnt_q, rd_cnt_d, n_q;
  logic          rd_en;

  assign rd_en = (state_q == pps_pkg::ST_SCAN) && (rd_cnt_q < n_q);

  always_ff @(posedge clk_i) begin
    if (is_write) wp_mem[in_idx] <= in_entry;
    if (rd_en) rd_data_q <= wp_mem[rd_cnt_q[IW-1:0]];
  end

  // Pose captured at query time.
  logic signed [23:0] px_q, py_q;
  logic [35:0]        la2_q;
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      px_q  <= in_px;
      py_q  <= in_py;
      la2_q <= look_q * look_q;
      n_q   <= (count_q > 11'(pps_pkg::MaxWaypoints)) ? NW'(pps_pkg::MaxWaypoints)
                                                       : NW'(count_q);
    end
  end

  logic             cordic_done;
  pps_pkg::sincos_t trig;
  pps_pkg::sincos_t trig_q;
  pps_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (is_query),
    .heading_i(in_hdg),
    .done_o   (cordic_done),
    .trig_o   (trig)
  );
  always_ff @(posedge clk_i) begin
    if (cordic_done) trig_q <= trig;
  end

  // Sweep pipeline.
  logic          va_q, v1_q, v2_q, v3_q, v4_q;
  logic [IW-1:0] ia_q, i1_q, i2_q, i3_q, i4_q;
  logic [15:0]   s1_q, s2_q, s3_q, s4_q;
  logic signed [24:0] dx_q, dy_q;
  logic signed [43:0] dxc_q, dys_q, dyc_q, dxs_q;
  logic signed [44:0] xs, ys;
  logic signed [28:0] xl_q, yl_q, y4_q;
  logic [28:0]        ay;
  logic [58:0]        d2_q;
  logic               cone_q;

  always_comb begin
    xs = (45'(dxc_q) + 45'(dys_q)) + 45'sd32768;
    ys = (45'(dyc_q) - 45'(dxs_q)) + 45'sd32768;
    ay = yl_q[28] ? 29'(-yl_q) : 29'(yl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      va_q <= rd_en;
      v1_q <= va_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ia_q  <= rd_cnt_q[IW-1:0];
    i1_q  <= ia_q;
    dx_q  <= 25'(signed'(rd_data_q[23:0])) - 25'(px_q);
    dy_q  <= 25'(signed'(rd_data_q[47:24])) - 25'(py_q);
    s1_q  <= rd_data_q[63:48];
    i2_q  <= i1_q;
    s2_q  <= s1_q;
    dxc_q <= dx_q * trig_q.cos_v;
    dys_q <= dy_q * trig_q.sin_v;
    dyc_q <= dy_q * trig_q.cos_v;
    dxs_q <= dx_q * trig_q.sin_v;
    i3_q  <= i2_q;
    s3_q  <= s2_q;
    xl_q  <= xs[44:16];
    yl_q  <= ys[44:16];
    i4_q  <= i3_q;
    s4_q  <= s3_q;
    y4_q  <= yl_q;
    d2_q  <= 59'(58'(xl_q * xl_q)) + 59'(58'(yl_q * yl_q));
    cone_q <= $signed({xl_q[28], xl_q}) > $signed({1'b0, ay});
  end

  // Best candidate.
  logic          found_q;
  logic [58:0]   best_d2_q;
  logic [IW-1:0] best_idx_q;
  logic signed [28:0] best_y_q;
  logic [15:0]   best_spd_q;
  logic          qual;
  assign qual = v4_q && cone_q && (d2_q >= 59'(la2_q)) && (!found_q || d2_q < best_d2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (is_query) begin
      found_q <= 1'b0;
    end else if (qual) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      best_idx_q <= '0;
      best_spd_q <= '0;
    end else if (qual) begin
      best_d2_q  <= d2_q;
      best_idx_q <= i4_q;
      best_y_q   <= y4_q;
      best_spd_q <= s4_q;
    end else if (v4_q && i4_q == '0) begin
      // Entry 0 supplies the speed when nothing qualifies.
      best_spd_q <= s4_q;
    end
  end

  // Products and division.
  logic [44:0]             gm_q;
  logic [31:0]             sp_q;
  logic                    div_start, div_done;
  logic [pps_pkg::DivW-1:0] quot;
  logic [28:0]             mag;
  assign mag = best_y_q[28] ? 29'(-best_y_q) : 29'(best_y_q);

  always_ff @(posedge clk_i) begin
    if (state_q == pps_pkg::ST_MUL) begin
      gm_q <= gain_q * mag;
      sp_q <= scale_q * best_spd_q;
    end
  end

  pps_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i((pps_pkg::DivW'(gm_q) << 14) + pps_pkg::DivW'(best_d2_q >> 1)),
    .divisor_i (best_d2_q),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  logic [15:0] steer_q, steer_d;
  logic [18:0] spd_r;
  logic [15:0] spd_sat;
  always_comb begin
    spd_r   = 19'((33'(sp_q) + 33'd8192) >> 14);
    spd_sat = (spd_r > 19'd65535) ? 16'hFFFF : spd_r[15:0];
    if (!drive_q || n_q == '0) spd_sat = '0;
  end

  always_comb begin
    steer_d = steer_q;
    if (div_done) begin
      if (best_y_q[28]) steer_d = (quot > 60'd32768) ? 16'h8000 : 16'(-quot[15:0]);
      else              steer_d = (quot > 60'd32767) ? 16'h7FFF : quot[15:0];
    end else if (state_q == pps_pkg::ST_MUL) begin
      steer_d = '0;
    end
  end
  always_ff @(posedge clk_i) steer_q <= steer_d;

  // Control.
  logic mul_phase_q, mul_phase_d;
  logic out_load;
  logic [47:0] out_data_q;
  logic        out_found_q, out_valid_q;

  always_comb begin
    state_d       = state_q;
    rd_cnt_d      = rd_cnt_q;
    mul_phase_d   = mul_phase_q;
    div_start     = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = (state_q == pps_pkg::ST_IDLE);
    case (state_q)
      pps_pkg::ST_IDLE: begin
        rd_cnt_d = '0;
        if (is_query) state_d = pps_pkg::ST_CORDIC;
      end
      pps_pkg::ST_CORDIC: begin
        if (cordic_done) state_d = pps_pkg::ST_SCAN;
      end
      pps_pkg::ST_SCAN: begin
        if (rd_en) rd_cnt_d = rd_cnt_q + 1'b1;
        if (!rd_en && !va_q && !v1_q && !v2_q && !v3_q && !v4_q) begin
          state_d     = pps_pkg::ST_MUL;
          mul_phase_d = 1'b0;
        end
      end
      pps_pkg::ST_MUL: begin
        mul_phase_d = 1'b1;
        if (mul_phase_q) begin
          if (found_q) begin
            div_start = 1'b1;
            state_d   = pps_pkg::ST_DIV;
          end else begin
            state_d = pps_pkg::ST_OUT;
          end
        end
      end
      pps_pkg::ST_DIV: begin
        if (div_done) state_d = pps_pkg::ST_OUT;
      end
      pps_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = pps_pkg::ST_IDLE;
        end
      end
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pps_pkg::ST_IDLE;
      rd_cnt_q    <= '0;
      mul_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      mul_phase_q <= mul_phase_d;
      if (out_load)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q  <= {6'd0, best_idx_q, spd_sat, steer_q};
      out_found_q <= found_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_SCAN) |-> (rd_cnt_q <= n_q))
    else $error("sweep counter ran past the entry count");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == pps_pkg::ST_DIV))
    else $error("divider finished outside the division phase");

  a_found_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_MUL && found_q) |-> (best_d2_q >= 59'(la2_q)))
    else $error("chosen target is inside the look-ahead distance");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_IDLE) |-> (!va_q && !v4_q))
    else $error("sweep pipeline active while idle");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pure pursuit target selector. The searched part
// of the waypoint table is filled first, then a directed table of items runs,
// followed by random writes and pose queries over several register settings.
// Each query result is compared field by field against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic signed [15:0] steering;
    logic [15:0]        speed_cmd;
    logic [9:0]         target_index;
    logic               target_found;
  } target_t;

  typedef struct {
    bit                 is_cfg;     // row only changes waypoint_count
    int                 new_count;
    bit                 query;
    logic [9:0]         idx;
    logic signed [23:0] wx, wy;
    logic [15:0]        wspd;
    logic signed [23:0] px, py;
    logic signed [15:0] hdg;
    bit                 has_exp;
    target_t            exp;
  } item_t;

  localparam int IdleLimit = 20000;
  localparam int FillCount = 128;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [17:0]  cfg_data_i;

  pure_pursuit_target_select_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the waypoint table and the registers.
  longint  mirror_x[pps_pkg::MaxWaypoints];
  longint  mirror_y[pps_pkg::MaxWaypoints];
  longint  mirror_spd[pps_pkg::MaxWaypoints];
  longint  la_dist, gain, scale, drive_en, wp_count;
  target_t expected_q[$];
  int      mismatches = 0;
  bit      no_idle = 1'b0;
  int      stall_left = 0;
  int      idle_cycles = 0;
  item_t   directed[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_row(item_t row);
    directed = {directed, row};
  endfunction

  function automatic target_t pursue(item_t it);
    longint arctan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                 256, 128, 64, 32, 16, 8, 4, 2};
    longint h, x, y, z, nx, c, s, n, dx, dy, xl, yl, ay, best_y;
    longint unsigned d2, best_d2, la2, num, q, mag, r;
    bit neg, found;
    int best_idx;
    target_t res;
    h = it.hdg;
    neg = 1'b0;
    if (h > 12868) begin
      h -= 25736;
      neg = 1'b1;
    end else if (h < -12868) begin
      h += 25736;
      neg = 1'b1;
    end
    x = 10188014;
    y = 0;
    z = h * 8;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_steps[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_steps[i];
      end
      x = nx;
    end
    c = (x + 128) >>> 8;
    s = (y + 128) >>> 8;
    if (neg) begin
      c = -c;
      s = -s;
    end
    la2 = la_dist * la_dist;
    n = wp_count > pps_pkg::MaxWaypoints ? pps_pkg::MaxWaypoints : wp_count;
    found = 1'b0;
    best_d2 = 0;
    best_idx = 0;
    best_y = 0;
    for (int i = 0; i < n; i++) begin
      dx = mirror_x[i] - it.px;
      dy = mirror_y[i] - it.py;
      xl = (dx * c + dy * s + 32768) >>> 16;
      yl = (dy * c - dx * s + 32768) >>> 16;
      ay = yl < 0 ? -yl : yl;
      d2 = longint'(xl * xl) + longint'(yl * yl);
      if (xl > ay && d2 >= la2 && (!found || d2 < best_d2)) begin
        found = 1'b1;
        best_d2 = d2;
        best_idx = i;
        best_y = yl;
      end
    end
    res = '0;
    if (found) begin
      mag = best_y < 0 ? -best_y : best_y;
      num = gain * mag * 16384;
      q = (num + best_d2 / 2) / best_d2;
      if (best_y < 0) res.steering = q > 32768 ? -16'sd32768 : -q;
      else res.steering = q > 32767 ? 16'sd32767 : q;
    end
    if (n > 0 && drive_en != 0) begin
      r = (scale * mirror_spd[best_idx] + 8192) >> 14;
      res.speed_cmd = r > 65535 ? 16'hFFFF : r[15:0];
    end
    res.target_index = best_idx[9:0];
    res.target_found = found;
    return res;
  endfunction

  // Drives one item; the caller returns right after a rising edge.
  task automatic send_item(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.query;
    s_axis_tdata  <= {6'b0, it.hdg, it.py, it.px, it.wspd, it.wy, it.wx, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.query) begin
      target_t res;
      res = pursue(it);
      if (it.has_exp && res != it.exp) begin
        $error("directed expectation disagrees with predictor");
        mismatches++;
      end
      expected_q = {expected_q, it.has_exp ? it.exp : res};
    end else begin
      mirror_x[it.idx]   = it.wx;
      mirror_y[it.idx]   = it.wy;
      mirror_spd[it.idx] = it.wspd;
    end
  endtask

  // Waits until every query has answered, then lets a trailing write settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[17:0];
    @(posedge clk_i);
    case (idx)
      pps_pkg::CfgLookAhead: la_dist  = val & 18'h3FFFF;
      pps_pkg::CfgSteerGain: gain     = val & 16'hFFFF;
      pps_pkg::CfgSpdScale:  scale    = val & 16'hFFFF;
      pps_pkg::CfgDriveEn:   drive_en = val & 1;
      pps_pkg::CfgWpCount:   wp_count = val & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic apply_config(longint la, longint kp, longint sc, longint en, longint cnt);
    write_reg(pps_pkg::CfgLookAhead, la);
    write_reg(pps_pkg::CfgSteerGain, kp);
    write_reg(pps_pkg::CfgSpdScale, sc);
    write_reg(pps_pkg::CfgDriveEn, en);
    write_reg(pps_pkg::CfgWpCount, cnt);
    cfg_we_i <= 1'b0;
  endtask

  // Most coordinates sit within 16 m of the origin so that targets exist.
  function automatic logic signed [23:0] near_coord();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 131071)) - 65536;
  endfunction

  function automatic item_t wr(int idx, int x, int y, int spd);
    item_t it;
    it = '{default: '0};
    it.idx = idx;
    it.wx = x;
    it.wy = y;
    it.wspd = spd;
    it.px = $urandom;
    it.py = $urandom;
    it.hdg = $urandom;
    return it;
  endfunction

  function automatic item_t qry(int x, int y, int h, bit zero);
    item_t it;
    it = '{default: '0};
    it.query = 1'b1;
    it.idx = $urandom;
    it.wx = $urandom;
    it.wy = $urandom;
    it.wspd = $urandom;
    it.px = x;
    it.py = y;
    it.hdg = h;
    it.has_exp = zero;
    return it;
  endfunction

  function automatic item_t set_count(int cnt);
    item_t it;
    it = '{default: '0};
    it.is_cfg = 1'b1;
    it.new_count = cnt;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    if ($urandom_range(0, 9) < 3) begin
      it = wr($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 63),
              near_coord(), near_coord(), $urandom);
    end else begin
      it = qry(0, 0, 0, 1'b0);
      it.px = $urandom_range(0, 4) == 0 ? $urandom : $signed($urandom_range(0, 262143)) - 131072;
      it.py = $urandom_range(0, 4) == 0 ? $urandom : $signed($urandom_range(0, 262143)) - 131072;
      it.hdg = $urandom_range(0, 6) == 0 ? $urandom : $urandom_range(0, 51472) - 25736;
    end
    return it;
  endfunction

  // Result side: random back-pressure.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left    <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with no query outstanding");
        mismatches++;
      end else begin
        target_t e;
        e = expected_q.pop_front();
        if (m_axis_tdata[15:0] !== e.steering) begin
          $error("steering expected %0d actual %0d", e.steering,
                 $signed(m_axis_tdata[15:0]));
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== e.speed_cmd) begin
          $error("speed_cmd expected %0d actual %0d", e.speed_cmd, m_axis_tdata[31:16]);
          mismatches++;
        end
        if (m_axis_tdata[41:32] !== e.target_index) begin
          $error("target_index expected %0d actual %0d", e.target_index,
                 m_axis_tdata[41:32]);
          mismatches++;
        end
        if (m_axis_tuser !== e.target_found) begin
          $error("target_found expected %0d actual %0d", e.target_found, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("pure_pursuit_target_select_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    la_dist = 7373;
    gain = 3072;
    scale = 12616;
    drive_en = 1;
    wp_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An empty table answers with all zero fields.
    send_item(qry(0, 0, 0, 1'b1));
    send_item(qry(8388607, -8388608, -32768, 1'b1));

    // Fill every entry that a search reaches, so none reads an unwritten one.
    for (int i = 0; i < FillCount; i++)
      send_item(wr(i, near_coord(), near_coord(), $urandom));

    add_row(set_count(16));
    add_row(wr(0, 32'h10000, 0, 16'hFFFF));
    add_row(wr(1, 0, 0, 100));            // sits on the vehicle
    add_row(wr(2, 32'h20000, 32'h8000, 4096));
    add_row(wr(3, 8388607, -8388608, 0));
    add_row(wr(4, 32'h10000, 0, 1234));   // ties with entry 0
    add_row(wr(1023, -8388608, -8388608, 16'hFFFF));
    add_row(qry(0, 0, 0, 1'b0));
    add_row(qry(0, 0, 25736, 1'b0));
    add_row(qry(0, 0, -25736, 1'b0));
    add_row(qry(0, 0, 32767, 1'b0));
    add_row(qry(0, 0, -32768, 1'b0));
    add_row(qry(0, 0, 12868, 1'b0));
    add_row(qry(0, 0, 16384, 1'b0));
    add_row(qry(-8388608, -8388608, 6434, 1'b0));
    add_row(qry(8388607, 8388607, 0, 1'b0));
    add_row(qry(32'h8000, 32'h4000, -1, 1'b0));
    add_row(set_count(FillCount));
    add_row(qry(0, 0, 0, 1'b0));
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_drained();
        write_reg(pps_pkg::CfgWpCount, directed[i].new_count);
        cfg_we_i <= 1'b0;
      end else begin
        send_item(directed[i]);
      end
    end

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      no_idle = (p == 5);
      case (p)
        0: apply_config(0, 0, 0, 0, 1);
        1: apply_config(262143, 65535, 65535, 1, 64);
        2: apply_config(7373, 3072, 12616, 1, FillCount);
        3: apply_config(1, 65535, 16384, 1, FillCount);
        default: apply_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 262143)
                                                        : $urandom_range(0, 16384),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 4) != 0, $urandom_range(1, 64));
      endcase
      for (int k = 0; k < 40; k++) begin
        it = random_item();
        send_item(it);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("pure_pursuit_target_select_unit verification clean");
    end else begin
      $display("pure_pursuit_target_select_unit verification failed");
    end
    $finish;
  end

endmodule
